// ===== design/at_reply_ssid_ip_extractor_top_assert.svh =====
// Assertion macros for the reply extractor checker.
`ifndef AT_REPLY_SSID_IP_EXTRACTOR_TOP_ASSERT_SVH
`define AT_REPLY_SSID_IP_EXTRACTOR_TOP_ASSERT_SVH

// Clocked check, masked while reset is low.
`define ATSIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ATSIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/atsie_pkg.sv =====
package atsie_pkg;

    // Display field length and the counter width that can hold it.
    localparam int FIELD_LEN = 10;
    localparam int CNT_W     = $clog2(FIELD_LEN + 1);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Saturating two-step counter (history depth, periods seen).
    typedef logic [1:0] t_sat2;
    localparam t_sat2 SAT_MAX = 2'd2;

endpackage

// ===== design/at_reply_ssid_ip_extractor_top.sv =====
// An accepted word is held in the input register, then moves into the result register,
// which drives the outputs, once that register is empty or being drained.
// One word per cycle while not stalled; one input register, one result register.
// The input side stalls only when both registers hold words and the output is stalled.
// Reset (synchronous, active low) empties both registers and clears all capture
// state and byte history; no word is shown until a new one is accepted.
module at_reply_ssid_ip_extractor_top
    import atsie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_echo_byte,
    output logic       o_ssid_write,
    output logic [3:0] o_ssid_pos,
    output logic       o_ip_write,
    output logic       o_ip_line,
    output logic [3:0] o_ip_pos,
    output logic       o_ssid_busy,
    output logic       o_ip_busy
);

    // Input register: holds the word until the result register can take it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Capture state, advanced once per word as it moves into the result register.
    logic [7:0]     r_last, n_last;
    logic [7:0]     r_before, n_before;
    t_sat2          r_seen, n_seen;
    logic           r_ssid_act, n_ssid_act;
    logic [CNT_W-1:0] r_ssid_cnt, n_ssid_cnt;
    logic           r_ip_act, n_ip_act;
    t_sat2          r_dots, n_dots;
    logic [CNT_W-1:0] r_ip_cnt1, n_ip_cnt1;
    logic [CNT_W-1:0] r_ip_cnt2, n_ip_cnt2;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_echo;
    logic       r_ssid_wr, n_ssid_wr;
    logic [3:0] r_ssid_pos, n_ssid_pos;
    logic       r_ip_wr, n_ip_wr;
    logic       r_ip_line, n_ip_line;
    logic [3:0] r_ip_pos, n_ip_pos;

    logic in_accept;
    logic advance;
    logic pair_hit;
    logic triple_hit;
    logic [7:0] c;

    // Advance the held word when the result register is empty or being drained.
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    assign c = r_in_byte;

    // Pattern tests only look at history that was actually received.
    assign pair_hit   = (r_seen != 2'd0) && (r_last == CH_COLON) && (c == CH_QUOTE);
    assign triple_hit = (r_seen == SAT_MAX) && (r_before == CH_P) &&
                        (r_last == CH_COMMA) && (c == CH_QUOTE);

    always_comb begin
        n_ssid_act = r_ssid_act;
        n_ssid_cnt = r_ssid_cnt;
        n_ssid_wr  = 1'b0;
        n_ssid_pos = 4'd0;
        n_ip_act   = r_ip_act;
        n_dots     = r_dots;
        n_ip_cnt1  = r_ip_cnt1;
        n_ip_cnt2  = r_ip_cnt2;
        n_ip_wr    = 1'b0;
        n_ip_line  = 1'b0;
        n_ip_pos   = 4'd0;

        // SSID capture: the opening pair restarts it, even mid-capture.
        if (pair_hit) begin
            n_ssid_act = 1'b1;
            n_ssid_cnt = '0;
        end else if (r_ssid_act) begin
            // Close on a quote, or on the first word after a full field.
            if ((c == CH_QUOTE) || (r_ssid_cnt >= CNT_W'(FIELD_LEN))) begin
                n_ssid_act = 1'b0;
            end else begin
                n_ssid_wr  = 1'b1;
                n_ssid_pos = 4'(r_ssid_cnt);
                n_ssid_cnt = r_ssid_cnt + 1'b1;
            end
        end

        // IP capture: opens only when idle; while open a quote just closes it.
        if (!r_ip_act) begin
            if (triple_hit) begin
                n_ip_act  = 1'b1;
                n_dots    = '0;
                n_ip_cnt1 = '0;
                n_ip_cnt2 = '0;
            end
        end else if (c == CH_QUOTE) begin
            n_ip_act = 1'b0;
        end else begin
            if ((c == CH_DOT) && (r_dots != SAT_MAX)) begin
                n_dots = r_dots + 2'd1;
            end
            // The second period itself already lands on line two.
            if (n_dots != SAT_MAX) begin
                if (r_ip_cnt1 < CNT_W'(FIELD_LEN)) begin
                    n_ip_wr   = 1'b1;
                    n_ip_pos  = 4'(r_ip_cnt1);
                    n_ip_cnt1 = r_ip_cnt1 + 1'b1;
                end
            end else if (r_ip_cnt2 < CNT_W'(FIELD_LEN)) begin
                n_ip_wr   = 1'b1;
                n_ip_line = 1'b1;
                n_ip_pos  = 4'(r_ip_cnt2);
                n_ip_cnt2 = r_ip_cnt2 + 1'b1;
            end
        end

        // Shift history; the seen count saturates at two.
        n_before = r_last;
        n_last   = c;
        n_seen   = (r_seen == SAT_MAX) ? r_seen : r_seen + 2'd1;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_before    <= '0;
            r_seen      <= '0;
            r_ssid_act  <= 1'b0;
            r_ssid_cnt  <= '0;
            r_ip_act    <= 1'b0;
            r_dots      <= '0;
            r_ip_cnt1   <= '0;
            r_ip_cnt2   <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_last     <= n_last;
                r_before   <= n_before;
                r_seen     <= n_seen;
                r_ssid_act <= n_ssid_act;
                r_ssid_cnt <= n_ssid_cnt;
                r_ip_act   <= n_ip_act;
                r_dots     <= n_dots;
                r_ip_cnt1  <= n_ip_cnt1;
                r_ip_cnt2  <= n_ip_cnt2;
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_echo     <= c;
            r_ssid_wr  <= n_ssid_wr;
            r_ssid_pos <= n_ssid_pos;
            r_ip_wr    <= n_ip_wr;
            r_ip_line  <= n_ip_line;
            r_ip_pos   <= n_ip_pos;
        end
    end

    // Busy flags are the state after the word, which the registers now hold.
    // The held state only moves together with a new result, so they stay aligned.
    assign o_valid      = r_out_valid;
    assign o_echo_byte  = r_echo;
    assign o_ssid_write = r_ssid_wr;
    assign o_ssid_pos   = r_ssid_pos;
    assign o_ip_write   = r_ip_wr;
    assign o_ip_line    = r_ip_line;
    assign o_ip_pos     = r_ip_pos;
    assign o_ssid_busy  = r_ssid_act;
    assign o_ip_busy    = r_ip_act;

endmodule

// ===== design/atsie_checker.sv =====
`include "at_reply_ssid_ip_extractor_top_assert.svh"

module atsie_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_echo_byte,
    input logic       o_ssid_write,
    input logic [3:0] o_ssid_pos,
    input logic       o_ip_write,
    input logic       o_ip_line,
    input logic [3:0] o_ip_pos,
    input logic       o_ssid_busy,
    input logic       o_ip_busy
);

    logic no_write;
    logic pos_zero;
    logic out_held;

    assign no_write = o_valid && !o_ip_write && !o_ssid_write;
    assign pos_zero = !o_ip_line && (o_ip_pos == 4'd0) && (o_ssid_pos == 4'd0);
    assign out_held = o_valid && i_stall;

    // A word stored into the SSID field leaves the capture open.
    `ATSIE_ASSERT(a_ssid_wr_busy, (o_valid && o_ssid_write) |-> o_ssid_busy, "ssid write while idle")

    // Same for the IP field.
    `ATSIE_ASSERT(a_ip_wr_busy, (o_valid && o_ip_write) |-> o_ip_busy, "ip write while idle")

    // Without a write, line and positions read zero.
    `ATSIE_ASSERT(a_idle_zero, no_write |-> pos_zero, "position set without write")

    // A stalled result holds its word.
    `ATSIE_ASSERT(a_hold, out_held |=> (o_valid && $stable(o_echo_byte)), "stalled word changed")

    // Reset empties the output.
    `ATSIE_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind at_reply_ssid_ip_extractor_top atsie_checker u_atsie_checker (.*);
